// ----- rtl/sh1024_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh1024_pkg
// Shared types, constants and the permutation round of the sponge hash engine.
// ----------------------------------------------------------------------------
package sh1024_pkg;

  typedef logic [63:0] word_t;
  typedef word_t [24:0] perm_t;

  localparam int unsigned PERM_WORDS  = 25;
  localparam int unsigned CHAIN_WORDS = 24;
  localparam int unsigned BLOCK_WORDS = 8;

  localparam word_t CHAIN_INIT_TOP = 64'd1024;
  localparam word_t CNT_FULL_FINAL = 64'hC000_0000_0000_0000;
  localparam word_t CNT_PAD_FINAL  = 64'h8000_0000_0000_0000;
  localparam word_t PAD_WORD       = 64'h8000_0000_0000_0000;
  localparam word_t PAD_BYTE       = 64'h0000_0000_0000_0080;

  localparam word_t ROUND_KEY [16] = '{
    64'hb7e151628aed2a6a, 64'haf82a3cd15dad4d7, 64'h9f4546922bb529ad,
    64'hfeca8c2c576ad359, 64'h3dd51950aed526b1, 64'h7baa32a15daa4d62,
    64'hf7546542bb549ac4, 64'h2ee8cb8d76a9b58b, 64'h5dd1971aed536b16,
    64'hbba32e35daa6d62c, 64'hb7065d63b54d2c5b, 64'hae4cbbcf6a9ad8b5,
    64'h9cd97696d5353169, 64'hf9f2ec25aa6ae2d1, 64'h33a5d94354d545a1,
    64'h674bb286a9aa8b42
  };

  localparam int unsigned ROT_AMT [5][5] = '{
    '{31, 1, 4, 21, 22}, '{19, 12, 15, 34, 13}, '{28, 35, 58, 9, 23},
    '{55, 18, 5, 27, 44}, '{14, 43, 53, 20, 25}
  };

  localparam int unsigned DEST_IDX [5][5] = '{
    '{0, 23, 16, 14, 7}, '{21, 19, 12, 5, 3}, '{17, 10, 8, 1, 24},
    '{13, 6, 4, 22, 15}, '{9, 2, 20, 18, 11}
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ABS_RUN,
    ST_ABS_FOLD,
    ST_FINAL,
    ST_SQ_RUN,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic absorb_load;
    logic round_en;
    logic fold;
    logic store;
    logic final_load;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic need_absorb;
    logic pend_last;
  } dp_status_t;

  function automatic word_t rotl(word_t x, int unsigned n);
    int unsigned m;
    m = n & 32'd63;
    if (m == 0) return x;
    return (x << m) | (x >> (64 - m));
  endfunction

  function automatic word_t rotr(word_t x, int unsigned n);
    int unsigned m;
    m = n & 32'd63;
    if (m == 0) return x;
    return (x >> m) | (x << (64 - m));
  endfunction

  function automatic perm_t perm_round(perm_t st_in, logic [3:0] rd);
    perm_t st;
    word_t b [5][5];
    word_t s0, s1, s2, s3, s4, a3, a4, par, mix;
    st = st_in;
    st[0] = st[0] ^ ROUND_KEY[rd];
    for (int j = 0; j < 5; j++) begin
      s0 = st[j];
      s1 = st[5 + j];
      s2 = st[10 + j];
      s3 = st[15 + j];
      s4 = st[20 + j];
      a4 = (s4 & s3) ^ s0;
      a3 = (s3 & s2) ^ s4;
      b[4][j] = a4;
      b[3][j] = a3;
      b[2][j] = (s2 & s1) ^ s3;
      b[1][j] = (a4 & s1) ^ s2;
      b[0][j] = (a4 & a3) ^ s1;
    end
    for (int r = 0; r < 5; r++) begin
      par = '0;
      mix = '0;
      for (int j = 0; j < 5; j++) begin
        par = par ^ b[r][j];
        mix = mix ^ rotl(b[r][j], ROT_AMT[r][j]);
      end
      for (int j = 0; j < 5; j++) begin
        st[DEST_IDX[r][j]] = b[r][j] ^ rotr(par, ROT_AMT[r][j]) ^ mix;
      end
    end
    return st;
  endfunction

endpackage

// ----- rtl/sh1024_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh1024 channel interfaces
// Message word request channel and digest word request channel.
// ----------------------------------------------------------------------------
interface sh1024_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] msg_word;
  logic [3:0]  byte_count;
  logic        last_item;
  modport source (output valid, msg_word, byte_count, last_item, input ready);
  modport sink (input valid, msg_word, byte_count, last_item, output ready);
endinterface

interface sh1024_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        digest_last;
  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface

// ----- rtl/sponge_hash_1024_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sponge_hash_1024_engine
// Streaming 1024-bit sponge hash: absorbs message words, emits digest words.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                              Handshake
//  in_chan   in   msg_word, byte_count, last_item      valid/ready
//  out_chan  out  digest_word, digest_last             valid/ready
//
// A word that does not start a new block is accepted in ST_IDLE and stored
// in ST_CHECK. A word that follows a full block first absorbs that block:
// the permutation unit runs one round per cycle, then the result is folded.
// A last word is followed by the squeeze rounds and then DIGEST_WORDS words.
// Reset is synchronous; out_chan stalls hold the block in its output phase.
module sponge_hash_1024_engine #(
  parameter int ROUNDS       = 16,
  parameter int DIGEST_WORDS = 16
) (
  input logic           clk,
  input logic           rst_n,
  sh1024_in_if.sink     in_chan,
  sh1024_out_if.source  out_chan
);
  import sh1024_pkg::*;

  localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int KW = (DIGEST_WORDS > 1) ? $clog2(DIGEST_WORDS) : 1;

  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [RW-1:0] rd;
  logic [KW-1:0] k;

  sh1024_ctrl #(
    .ROUNDS(ROUNDS), .DIGEST_WORDS(DIGEST_WORDS), .RW(RW), .KW(KW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_last  (out_chan.digest_last),
    .status    (status),
    .cmd       (cmd),
    .rd        (rd),
    .k         (k)
  );

  sh1024_dpath #(.RW(RW), .KW(KW)) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .rd          (rd),
    .k           (k),
    .msg_word    (in_chan.msg_word),
    .byte_count  (in_chan.byte_count),
    .last_item   (in_chan.last_item),
    .status      (status),
    .digest_word (out_chan.digest_word)
  );

endmodule

// ----- rtl/sh1024_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh1024_ctrl
// Sequencer for request intake, absorb and squeeze rounds and digest output.
// ----------------------------------------------------------------------------
module sh1024_ctrl #(
  parameter int ROUNDS       = 16,
  parameter int DIGEST_WORDS = 16,
  parameter int RW           = 4,
  parameter int KW           = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_last,
  input  sh1024_pkg::dp_status_t status,
  output sh1024_pkg::dp_cmd_t    cmd,
  output logic [RW-1:0]          rd,
  output logic [KW-1:0]          k
);
  import sh1024_pkg::*;

  ctrl_state_t   state_r, state_nxt;
  logic [RW-1:0] rd_r, rd_nxt;
  logic [KW-1:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rd_r    <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      rd_r    <= rd_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rd_nxt    = rd_r;
    k_nxt     = k_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.need_absorb) begin
          cmd.absorb_load = 1'b1;
          rd_nxt          = '0;
          state_nxt       = ST_ABS_RUN;
        end else begin
          cmd.store = 1'b1;
          state_nxt = status.pend_last ? ST_FINAL : ST_IDLE;
        end
      end
      ST_ABS_RUN: begin
        cmd.round_en = 1'b1;
        rd_nxt       = rd_r + 1'b1;
        if (rd_r == RW'(ROUNDS - 1)) state_nxt = ST_ABS_FOLD;
      end
      ST_ABS_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_FINAL: begin
        cmd.final_load = 1'b1;
        rd_nxt         = '0;
        state_nxt      = ST_SQ_RUN;
      end
      ST_SQ_RUN: begin
        cmd.round_en = 1'b1;
        rd_nxt       = rd_r + 1'b1;
        if (rd_r == RW'(ROUNDS - 1)) begin
          k_nxt     = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (k_r == KW'(DIGEST_WORDS - 1)) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_last = (k_r == KW'(DIGEST_WORDS - 1));
  assign rd       = rd_r;
  assign k        = k_r;

endmodule

// ----- rtl/sh1024_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh1024_dpath
// Chaining store, block buffer, counters and the one-round-per-cycle permutation.
// ----------------------------------------------------------------------------
module sh1024_dpath #(
  parameter int RW = 4,
  parameter int KW = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sh1024_pkg::dp_cmd_t    cmd,
  input  logic [RW-1:0]          rd,
  input  logic [KW-1:0]          k,
  input  logic [63:0]            msg_word,
  input  logic [3:0]             byte_count,
  input  logic                   last_item,
  output sh1024_pkg::dp_status_t status,
  output logic [63:0]            digest_word
);
  import sh1024_pkg::*;

  word_t       chain_r [CHAIN_WORDS];
  word_t       buf_r [BLOCK_WORDS];
  word_t       count_r;
  logic [6:0]  bpos_r;
  perm_t       perm_r;
  word_t       pend_word_r;
  logic [3:0]  pend_n_r;
  logic        pend_last_r;
  logic [3:0]  n_eff;
  word_t       in_mask;
  word_t       tail [BLOCK_WORDS];
  word_t       fin_chain [CHAIN_WORDS];
  logic [2:0]  wpos;
  logic [2:0]  rem;
  logic [4:0]  pidx;
  logic [4:0]  cidx;

  always_comb begin
    if (!last_item || byte_count > 4'd8) n_eff = 4'd8;
    else n_eff = byte_count;
    in_mask = '1;
    if (n_eff < 4'd8) in_mask = ~64'd0 << {(4'd8 - n_eff), 3'b000};
  end

  assign wpos = bpos_r[5:3];
  assign rem  = bpos_r[2:0];

  always_comb begin
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      if (bpos_r[6] || 3'(i) < wpos) tail[i] = buf_r[i];
      else if (3'(i) == wpos) begin
        if (rem != 3'd0) tail[i] = buf_r[i] ^ (PAD_BYTE << {(3'd7 - rem), 3'b000});
        else tail[i] = PAD_WORD;
      end else tail[i] = '0;
    end
    for (int i = 0; i < 16; i++) fin_chain[i] = chain_r[i + 8];
    for (int i = 0; i < BLOCK_WORDS; i++) fin_chain[16 + i] = tail[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < CHAIN_WORDS; i++) begin
        chain_r[i] <= (i == CHAIN_WORDS - 1) ? CHAIN_INIT_TOP : '0;
      end
      count_r <= '0;
      bpos_r  <= '0;
    end else begin
      if (cmd.absorb_load) begin
        for (int i = 0; i < 8; i++) begin
          chain_r[i]      <= chain_r[16 + i];
          chain_r[8 + i]  <= buf_r[i];
          chain_r[16 + i] <= chain_r[i];
        end
        count_r <= count_r + 64'd1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < CHAIN_WORDS; i++) chain_r[i] <= chain_r[i] ^ perm_r[i + 1];
        bpos_r <= '0;
      end
      if (cmd.store && pend_n_r != 4'd0) bpos_r <= bpos_r + 7'(pend_n_r);
      if (cmd.final_load) begin
        for (int i = 0; i < CHAIN_WORDS; i++) chain_r[i] <= fin_chain[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_word_r <= msg_word & in_mask;
      pend_n_r    <= n_eff;
      pend_last_r <= last_item;
    end
    if (cmd.store && pend_n_r != 4'd0) buf_r[wpos] <= pend_word_r;
    if (cmd.absorb_load) begin
      perm_r[0] <= count_r;
      for (int i = 0; i < 8; i++) perm_r[1 + i] <= buf_r[i];
      for (int i = 0; i < 16; i++) perm_r[9 + i] <= chain_r[i];
    end else if (cmd.final_load) begin
      perm_r[0] <= bpos_r[6] ? CNT_FULL_FINAL : CNT_PAD_FINAL;
      for (int i = 0; i < CHAIN_WORDS; i++) perm_r[1 + i] <= fin_chain[i];
    end else if (cmd.round_en) begin
      perm_r <= perm_round(perm_r, 4'(rd));
    end
  end

  assign status.need_absorb = (pend_n_r != 4'd0) && bpos_r[6];
  assign status.pend_last   = pend_last_r;

  assign pidx        = 5'(k) + 5'd8;
  assign cidx        = 5'(k) + 5'd7;
  assign digest_word = perm_r[pidx] ^ chain_r[cidx];

endmodule

// ----- rtl/sh1024_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh1024_checker
// Port-level checks of request ordering for the sponge hash engine.
// ----------------------------------------------------------------------------
module sh1024_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] digest_word,
  input logic        digest_last
);

  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !out_valid) else $error("input taken during output");

  a_in_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("output right after input");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && digest_last) |=> !out_valid)
    else $error("output continues after last digest word");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(digest_word)))
    else $error("stalled digest request changed");

endmodule

bind sponge_hash_1024_engine sh1024_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .digest_word (out_chan.digest_word),
  .digest_last (out_chan.digest_last)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sponge hash engine testbench
// Streams messages of assorted lengths into the engine, computes each digest
// in a behavioral model of the sponge, and checks every digest word in order.
// ----------------------------------------------------------------------------
import sh1024_pkg::*;

class digest_scoreboard;
  word_t chain [24];
  word_t blk [8];
  word_t blk_cnt;
  int unsigned fill;
  word_t want_word [$];
  bit want_last [$];
  int unsigned n_err;
  int unsigned n_words;

  function new();
    n_err = 0;
    n_words = 0;
    clear_state();
  endfunction

  function void clear_state();
    foreach (chain[i]) chain[i] = '0;
    foreach (blk[i]) blk[i] = '0;
    chain[23] = 64'd1024;
    blk_cnt = '0;
    fill = 0;
  endfunction

  function word_t rol(word_t x, int unsigned n);
    if (n == 0) return x;
    return (x << n) | (x >> (64 - n));
  endfunction

  function word_t ror(word_t x, int unsigned n);
    if (n == 0) return x;
    return (x >> n) | (x << (64 - n));
  endfunction

  function void scramble(ref word_t st [25]);
    word_t b [5][5];
    word_t s0, s1, s2, s3, s4, a3, a4, par, mix;
    for (int rd = 0; rd < 16; rd++) begin
      st[0] ^= ROUND_KEY[rd];
      for (int j = 0; j < 5; j++) begin
        s0 = st[j];
        s1 = st[5 + j];
        s2 = st[10 + j];
        s3 = st[15 + j];
        s4 = st[20 + j];
        a4 = (s4 & s3) ^ s0;
        a3 = (s3 & s2) ^ s4;
        b[4][j] = a4;
        b[3][j] = a3;
        b[2][j] = (s2 & s1) ^ s3;
        b[1][j] = (a4 & s1) ^ s2;
        b[0][j] = (a4 & a3) ^ s1;
      end
      for (int r = 0; r < 5; r++) begin
        par = '0;
        mix = '0;
        for (int j = 0; j < 5; j++) begin
          par ^= b[r][j];
          mix ^= rol(b[r][j], ROT_AMT[r][j]);
        end
        for (int j = 0; j < 5; j++) st[DEST_IDX[r][j]] = b[r][j] ^ ror(par, ROT_AMT[r][j]) ^ mix;
      end
    end
  endfunction

  function void absorb();
    word_t st [25];
    word_t old [8];
    st[0] = blk_cnt;
    blk_cnt++;
    for (int i = 0; i < 8; i++) st[1 + i] = blk[i];
    for (int i = 0; i < 16; i++) st[9 + i] = chain[i];
    for (int i = 0; i < 8; i++) old[i] = chain[i];
    for (int i = 0; i < 8; i++) chain[i] = chain[i + 16];
    for (int i = 0; i < 8; i++) chain[8 + i] = blk[i];
    for (int i = 0; i < 8; i++) chain[16 + i] = old[i];
    scramble(st);
    for (int i = 0; i < 24; i++) chain[i] ^= st[i + 1];
    fill = 0;
  endfunction

  function void note_request(word_t w, logic [3:0] cnt, bit is_last);
    word_t st [25];
    int unsigned n, wi, rem;
    n = (!is_last || cnt > 8) ? 8 : cnt;
    if (n > 0) begin
      if (fill >= 64) absorb();
      if (n < 8) w &= ~64'd0 << (8 * (8 - n));
      blk[(fill >> 3) & 7] = w;
      fill += n;
    end
    if (!is_last) return;
    for (int i = 0; i < 16; i++) chain[i] = chain[i + 8];
    if (fill >= 64) begin
      for (int i = 0; i < 8; i++) chain[16 + i] = blk[i];
      blk_cnt = CNT_FULL_FINAL;
    end else begin
      wi = fill >> 3;
      rem = fill & 7;
      for (int i = 0; i < 8; i++) chain[16 + i] = '0;
      for (int i = 0; i < wi; i++) chain[16 + i] = blk[i];
      if (rem != 0) chain[16 + wi] = blk[wi] ^ (PAD_BYTE << (8 * (7 - rem)));
      else chain[16 + wi] = PAD_WORD;
      blk_cnt = CNT_PAD_FINAL;
    end
    st[0] = blk_cnt;
    for (int i = 0; i < 24; i++) st[1 + i] = chain[i];
    scramble(st);
    for (int k = 0; k < 16; k++) begin
      want_word.push_back(st[k + 8] ^ chain[k + 7]);
      want_last.push_back(k == 15);
    end
    clear_state();
  endfunction

  function void check_digest(word_t w, bit lst);
    n_words++;
    if (want_word.size() == 0) begin
      n_err++;
      if (n_err <= 10) $display("ERROR: unexpected digest word %h", w);
      return;
    end
    if (want_word[0] !== w || want_last[0] !== lst) begin
      n_err++;
      if (n_err <= 10)
        $display("ERROR: digest exp %h/%0b got %h/%0b", want_word[0], want_last[0], w, lst);
    end
    void'(want_word.pop_front());
    void'(want_last.pop_front());
  endfunction
endclass

module tb_top;
  logic clk;
  logic rst_n;
  sh1024_in_if in_chan ();
  sh1024_out_if out_chan ();
  digest_scoreboard sb;
  int unsigned n_msgs;
  int unsigned n_items;
  int unsigned burst_left;
  bit hold_off;
  bit tail_seen [9];

  sponge_hash_1024_engine dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan.sink),
    .out_chan(out_chan.source)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_request(word_t w, logic [3:0] cnt, bit is_last);
    while (burst_left == 0) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
      if ($urandom_range(3) == 0) burst_left = $urandom_range(12, 1);
    end
    in_chan.valid <= 1'b1;
    in_chan.msg_word <= w;
    in_chan.byte_count <= cnt;
    in_chan.last_item <= is_last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_request(w, cnt, is_last);
    burst_left--;
    n_items++;
    if (is_last) n_msgs++;
  endtask

  task automatic send_message(int unsigned n_full, logic [3:0] tail_cnt, bit rand_data);
    word_t w;
    for (int i = 0; i < n_full; i++) begin
      w = rand_data ? {$urandom, $urandom} : word_t'(i);
      send_request(w, 4'($urandom), 1'b0);
    end
    w = rand_data ? {$urandom, $urandom} : '1;
    send_request(w, tail_cnt, 1'b1);
    if (tail_cnt <= 8) tail_seen[tail_cnt] = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_digest(out_chan.digest_word, out_chan.digest_last);
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) out_chan.ready <= 1'b0;
      else if (($urandom_range(9) < 3) && ($urandom_range(1) == 0)) out_chan.ready <= 1'b0;
      else out_chan.ready <= 1'b1;
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (n_msgs == 4);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    int unsigned wait_cnt;
    int unsigned len;
    int unsigned n_tails;
    sb = new();
    n_msgs = 0;
    n_items = 0;
    burst_left = 1000;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.msg_word = '0;
    in_chan.byte_count = '0;
    in_chan.last_item = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_message(0, 4'd0, 1'b0);
    send_message(0, 4'd8, 1'b0);
    send_message(0, 4'd15, 1'b1);
    send_message(7, 4'd8, 1'b0);
    send_message(8, 4'd0, 1'b1);
    send_message(8, 4'd3, 1'b1);
    send_message(7, 4'd4, 1'b1);
    send_message(3, 4'd9, 1'b1);
    burst_left = 0;
    while (n_items < 450) begin
      len = ($urandom_range(4) == 0) ? $urandom_range(40) : $urandom_range(17);
      send_message(len, 4'($urandom_range(15)), 1'b1);
    end
    in_chan.valid <= 1'b0;
    wait_cnt = 0;
    while (sb.want_word.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (100) @(posedge clk);
    n_tails = 0;
    foreach (tail_seen[i]) if (tail_seen[i]) n_tails++;
    $display("Ran %0d messages from %0d words, checked %0d digest words.",
      n_msgs, n_items, sb.n_words);
    $display("Final words used %0d of the 9 in-range byte counts, plus counts above eight.",
      n_tails);
    if (sb.n_err == 0 && sb.want_word.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches: %0d, words missing: %0d", sb.n_err, sb.want_word.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
